// ===== rtl/core/pvsrld_pkg.sv =====
// Package for the PVS run-length leaf decoder: item structs, opcodes,
// register map and sizing constants.
// No dependencies.
package pvsrld_pkg;

   // Sizing
   localparam int MAX_LEAVES      = 1024;
   localparam int LEAF_BITS       = 10;
   localparam int CURSOR_BITS     = 11;
   localparam int POLY_BITS       = 16;
   localparam int LEAVES_PER_BYTE = 8;
   localparam int PICK_BITS       = 3;

   // Opcodes of an input item
   localparam logic [1:0] OP_LOAD  = 2'd0;
   localparam logic [1:0] OP_START = 2'd1;
   localparam logic [1:0] OP_BYTE  = 2'd2;

   // Register map (word index)
   localparam logic REG_LEAF_COUNT = 1'b0;

   typedef struct packed {
      logic [1:0]           opcode;
      logic [LEAF_BITS-1:0] leaf_index;
      logic [POLY_BITS-1:0] first_poly;
      logic [POLY_BITS-1:0] stop_poly;
      logic [7:0]           pvs_byte;
   } req_item_type;

   typedef struct packed {
      logic [LEAF_BITS-1:0] visible_leaf;
      logic [POLY_BITS-1:0] range_first;
      logic [POLY_BITS-1:0] range_end;
      logic                 last_of_byte;
      logic                 row_done;
   } rsp_item_type;

   typedef struct packed {
      logic [POLY_BITS-1:0] first_poly;
      logic [POLY_BITS-1:0] stop_poly;
   } leaf_entry_type;

endpackage

// ===== rtl/core/pvs_run_length_leaf_decoder_top.sv =====
// PVS run-length leaf decoder: leaf table memory, row sequencer and result
// pipeline. Depends on pvsrld_pkg.
//
// Usage:
//   req channel (valid/ready) carries one item: load a leaf table entry,
//   start a new row, or deliver one PVS byte. rsp channel (valid/ready)
//   returns one item per visible leaf: leaf index and polygon range.
//   leaf_count is written over the APB-style port at byte address 0.
// Flow:
//   Load, start, skip-count and zero bytes never hold req_ready low. A
//   nonzero byte holds req_ready low until every set bit below the leaf
//   limit has been read, since the single read port of the leaf table
//   is used once per visible leaf. A result passes the byte mask, the read
//   stage and output register; results follow one per cycle while rsp_ready is high.
// Reset:
//   Cursor, skip flag, leaf_count and all valid flags clear. The leaf
//   table is not cleared; entries must be loaded before they are used.
// Stall:
//   When rsp_ready is low the output register holds its item, the read
//   stage behind it holds once full, and the sequencer then stops issuing table reads.
module pvs_run_length_leaf_decoder_top
   import pvsrld_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   // input items
   input  logic         req_valid,
   output logic         req_ready,
   input  req_item_type req_item,
   // result items
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output rsp_item_type rsp_item,
   // configuration
   input  logic         psel,
   input  logic         penable,
   input  logic         pwrite,
   input  logic [2:0]   paddr,
   input  logic [31:0]  pwdata,
   output logic [31:0]  prdata,
   output logic         pready
);

   // Registers
   logic [CURSOR_BITS-1:0]     leaf_count_ff;
   logic [CURSOR_BITS-1:0]     cursor_ff, cursor_in;
   logic                       skip_ff, skip_in;
   logic [LEAVES_PER_BYTE-1:0] mask_ff, mask_in;
   logic [CURSOR_BITS-1:0]     base_ff, base_in;
   logic                       s1_valid_ff;
   logic [LEAF_BITS-1:0]       s1_leaf_ff;
   logic                       s1_last_ff;
   logic                       s1_done_ff;
   logic                       out_valid_ff;
   rsp_item_type               out_item_ff;

   // Leaf table
   leaf_entry_type             leaf_mem [MAX_LEAVES];
   leaf_entry_type             rd_data_ff;

   logic [CURSOR_BITS-1:0]     limit;
   logic                       req_fire;
   logic                       mem_we;
   logic                       out_free;
   logic                       s1_move;
   logic                       issue;
   logic [PICK_BITS-1:0]       pick_idx;
   logic [LEAVES_PER_BYTE-1:0] pick_bit;
   logic [LEAVES_PER_BYTE-1:0] mask_rest;
   logic [CURSOR_BITS-1:0]     pick_leaf;
   logic [CURSOR_BITS:0]       pick_next;
   logic [LEAVES_PER_BYTE-1:0] in_range;
   logic [CURSOR_BITS:0]       skip_sum;
   logic [CURSOR_BITS:0]       step_sum;
   logic [CURSOR_BITS:0]       limit_ext;
   logic                       csr_write;

   // Configuration port
   assign pready    = 1'b1;
   assign csr_write = psel & penable & pwrite;
   assign prdata    = (paddr[2] == REG_LEAF_COUNT)
                      ? {{(32-CURSOR_BITS){1'b0}}, leaf_count_ff} : 32'd0;

   // Leaf limit: leaf_count saturated at the table depth
   assign limit     = (leaf_count_ff > CURSOR_BITS'(MAX_LEAVES))
                      ? CURSOR_BITS'(MAX_LEAVES) : leaf_count_ff;
   assign limit_ext = {1'b0, limit};

   // Input side: accept only when no byte is still being walked
   assign req_ready = (mask_ff == '0);
   assign req_fire  = req_valid & req_ready;
   assign mem_we    = req_fire && (req_item.opcode == OP_LOAD);

   // Leaves of this byte that lie below the limit
   always_comb begin
      for (int i = 0; i < LEAVES_PER_BYTE; i++) begin
         in_range[i] = ({1'b0, cursor_ff} + (CURSOR_BITS+1)'(i)) < limit_ext;
      end
   end

   assign skip_sum = {1'b0, cursor_ff}
                     + {{(CURSOR_BITS-10){1'b0}}, req_item.pvs_byte, 3'b000};
   assign step_sum = {1'b0, cursor_ff} + (CURSOR_BITS+1)'(LEAVES_PER_BYTE);

   // Row sequencer next state
   always_comb begin
      cursor_in = cursor_ff;
      skip_in   = skip_ff;
      mask_in   = mask_ff;
      base_in   = base_ff;
      if (issue) begin
         mask_in = mask_rest;
      end
      if (req_fire) begin
         priority if (req_item.opcode == OP_START) begin
            cursor_in = '0;
            skip_in   = 1'b0;
         end else if (req_item.opcode != OP_BYTE || cursor_ff >= limit) begin
            // load, unused opcode or finished row: sequencer untouched
         end else if (skip_ff) begin
            cursor_in = (skip_sum < limit_ext) ? skip_sum[CURSOR_BITS-1:0] : limit;
            skip_in   = 1'b0;
         end else if (req_item.pvs_byte == 8'd0) begin
            skip_in = 1'b1;
         end else begin
            mask_in   = req_item.pvs_byte & in_range;
            base_in   = cursor_ff;
            cursor_in = (step_sum < limit_ext) ? step_sum[CURSOR_BITS-1:0] : limit;
         end
      end
   end

   // Lowest pending bit of the byte
   always_comb begin
      pick_idx = '0;
      for (int i = LEAVES_PER_BYTE - 1; i >= 0; i--) begin
         if (mask_ff[i]) begin
            pick_idx = PICK_BITS'(i);
         end
      end
   end

   assign pick_bit  = LEAVES_PER_BYTE'(1) << pick_idx;
   assign mask_rest = mask_ff & ~pick_bit;
   assign pick_leaf = base_ff + {{(CURSOR_BITS-PICK_BITS){1'b0}}, pick_idx};
   assign pick_next = {1'b0, pick_leaf} + (CURSOR_BITS+1)'(1);

   // Result pipeline flow: read stage, then output register
   assign out_free = ~out_valid_ff | rsp_ready;
   assign s1_move  = s1_valid_ff & out_free;
   assign issue    = (mask_ff != '0) & (~s1_valid_ff | out_free);

   // Leaf table: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         leaf_mem[req_item.leaf_index] <= '{first_poly: req_item.first_poly,
                                            stop_poly:  req_item.stop_poly};
      end
      if (issue) begin
         rd_data_ff <= leaf_mem[pick_leaf[LEAF_BITS-1:0]];
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         leaf_count_ff <= '0;
         cursor_ff     <= '0;
         skip_ff       <= 1'b0;
         mask_ff       <= '0;
         s1_valid_ff   <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         if (csr_write && paddr[2] == REG_LEAF_COUNT) begin
            leaf_count_ff <= pwdata[CURSOR_BITS-1:0];
         end
         cursor_ff <= cursor_in;
         skip_ff   <= skip_in;
         mask_ff   <= mask_in;
         if (issue) begin
            s1_valid_ff <= 1'b1;
         end else if (s1_move) begin
            s1_valid_ff <= 1'b0;
         end
         if (s1_move) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      base_ff <= base_in;
      if (issue) begin
         s1_leaf_ff <= pick_leaf[LEAF_BITS-1:0];
         s1_last_ff <= (mask_rest == '0);
         s1_done_ff <= (pick_next >= limit_ext);
      end
      if (s1_move) begin
         out_item_ff <= '{visible_leaf: s1_leaf_ff,
                          range_first:  rd_data_ff.first_poly,
                          range_end:    rd_data_ff.stop_poly,
                          last_of_byte: s1_last_ff,
                          row_done:     s1_done_ff};
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_item  = out_item_ff;

endmodule
